### sv/indexed_list_store_core_assert.svh
// ----------------------------------------------------------------------------
// Indexed list store assertion macros
// Concurrent assertion wrappers clocked on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_CORE_ASSERT_SVH
`define INDEXED_LIST_STORE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ILS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("indexed list store assertion failed");
`define ILS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("indexed list store reset assertion failed");
`else
`define ILS_ASSERT(lbl, prop)
`define ILS_ASSERT_RST(lbl, prop)
`endif

`endif

### sv/ils_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list store package
// Sizes, operation codes and the command broadcast to the cell chain.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int CAPACITY   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int OP_W       = 4;
  localparam int POS_W      = 8;
  localparam int ITEM_W     = 32;
  localparam int SIZE_W     = 6;
  localparam int CMP_W      = POS_W + CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR     = 4'd0,
    OP_INS_FRONT = 4'd1,
    OP_INS_BACK  = 4'd2,
    OP_INS_AT    = 4'd3,
    OP_DEL_AT    = 4'd4,
    OP_DEL_FRONT = 4'd5,
    OP_DEL_BACK  = 4'd6,
    OP_GET_AT    = 4'd7,
    OP_GET_FRONT = 4'd8,
    OP_GET_BACK  = 4'd9
  } op_e;

  typedef struct packed {
    logic             clr;
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] point;
  } cell_cmd_t;

endpackage

### sv/ils_cell.sv
// ----------------------------------------------------------------------------
// Indexed list store cell
// One element word; takes its left neighbor or the insert value on insert, its right on delete.
// ----------------------------------------------------------------------------
module ils_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ils_pkg::cell_cmd_t             cmd_i,
  input  logic [ils_pkg::IDX_W-1:0]      own_idx_i,
  input  logic [ils_pkg::VALUE_BITS-1:0] left_i,
  input  logic [ils_pkg::VALUE_BITS-1:0] right_i,
  input  logic [ils_pkg::VALUE_BITS-1:0] ins_value_i,
  output logic [ils_pkg::VALUE_BITS-1:0] value_o
);

  logic [ils_pkg::VALUE_BITS-1:0] value_q;
  logic [ils_pkg::VALUE_BITS-1:0] value_d;

  always_comb begin
    value_d = value_q;
    if (cmd_i.clr) begin
      value_d = '0;
    end else if (cmd_i.ins) begin
      if (own_idx_i > cmd_i.point) begin
        value_d = left_i;
      end else if (own_idx_i == cmd_i.point) begin
        value_d = ins_value_i;
      end
    end else if (cmd_i.del) begin
      if (own_idx_i >= cmd_i.point) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

### sv/ils_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed list store controller
// Decodes a request against the element count and drives the cell chain.
// ----------------------------------------------------------------------------
module ils_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  logic [ils_pkg::OP_W-1:0]   operation_i,
  input  logic [ils_pkg::POS_W-1:0]  position_i,
  output ils_pkg::cell_cmd_t         cmd_o,
  output logic                       err_o,
  output logic [ils_pkg::IDX_W-1:0]  rd_idx_o,
  output logic [ils_pkg::CNT_W-1:0]  count_o,
  output logic [ils_pkg::CNT_W-1:0]  count_next_o
);

  logic [ils_pkg::CNT_W-1:0] count_q;
  logic [ils_pkg::CNT_W-1:0] count_d;
  logic                      full;
  logic                      empty;
  logic                      pos_ok;
  logic [ils_pkg::IDX_W-1:0] pos_idx;
  logic [ils_pkg::IDX_W-1:0] last_idx;
  logic [ils_pkg::IDX_W-1:0] end_idx;
  ils_pkg::cell_cmd_t        cmd;
  logic                      err;

  assign full     = (count_q == ils_pkg::CNT_W'(ils_pkg::CAPACITY));
  assign empty    = (count_q == '0);
  assign pos_ok   = (ils_pkg::CMP_W'(position_i) < ils_pkg::CMP_W'(count_q));
  assign pos_idx  = ils_pkg::IDX_W'(position_i);
  assign end_idx  = ils_pkg::IDX_W'(count_q);
  assign last_idx = ils_pkg::IDX_W'(count_q - ils_pkg::CNT_W'(1));

  always_comb begin
    cmd   = '0;
    err   = 1'b0;
    case (ils_pkg::op_e'(operation_i))
      ils_pkg::OP_CLEAR: begin
        cmd.clr = 1'b1;
      end
      ils_pkg::OP_INS_FRONT: begin
        err       = full;
        cmd.ins   = !full;
        cmd.point = '0;
      end
      ils_pkg::OP_INS_BACK: begin
        err       = full;
        cmd.ins   = !full;
        cmd.point = end_idx;
      end
      ils_pkg::OP_INS_AT: begin
        err       = full || ((position_i != '0) && !pos_ok);
        cmd.ins   = !err;
        cmd.point = pos_idx;
      end
      ils_pkg::OP_DEL_AT: begin
        err       = !pos_ok;
        cmd.del   = pos_ok;
        cmd.point = pos_idx;
      end
      ils_pkg::OP_DEL_FRONT: begin
        err       = empty;
        cmd.del   = !empty;
        cmd.point = '0;
      end
      ils_pkg::OP_DEL_BACK: begin
        err       = empty;
        cmd.del   = !empty;
        cmd.point = last_idx;
      end
      ils_pkg::OP_GET_AT: begin
        err       = !pos_ok;
        cmd.point = pos_idx;
      end
      ils_pkg::OP_GET_FRONT: begin
        err       = empty;
        cmd.point = '0;
      end
      ils_pkg::OP_GET_BACK: begin
        err       = empty;
        cmd.point = last_idx;
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd.clr) begin
      count_d = '0;
    end else if (cmd.ins) begin
      count_d = count_q + ils_pkg::CNT_W'(1);
    end else if (cmd.del) begin
      count_d = count_q - ils_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (acc_i) begin
      count_q <= count_d;
    end
  end

  always_comb begin
    cmd_o     = cmd;
    cmd_o.clr = cmd.clr && acc_i;
    cmd_o.ins = cmd.ins && acc_i;
    cmd_o.del = cmd.del && acc_i;
  end

  assign err_o        = err;
  assign rd_idx_o     = cmd.point;
  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

### sv/indexed_list_store_core.sv
// ----------------------------------------------------------------------------
// Indexed list store core
// Bounded ordered list of value words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// A request (operation_i, position_i, item_value_i) is taken at a rising
// clock edge where start_i is high and busy_o is low. busy_o stays low, so
// one request can be issued in every cycle.
// Exactly one result follows each request, in the next cycle: done_o is high
// for one cycle while status_o, read_value_o, size_now_o and is_empty_o
// are valid. The receiver cannot stall; results are not held.
// Inserts and deletes are not sequenced: every cell loads its left or right
// neighbor in parallel; a read selects one cell through a multiplexer over
// the chain.
// Reset clears every cell and the element count, so the list is empty.
// ----------------------------------------------------------------------------
module indexed_list_store_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [ils_pkg::OP_W-1:0]     operation_i,
  input  logic [ils_pkg::POS_W-1:0]    position_i,
  input  logic [ils_pkg::ITEM_W-1:0]   item_value_i,
  output logic                         done_o,
  output logic                         status_o,
  output logic [ils_pkg::ITEM_W-1:0]   read_value_o,
  output logic [ils_pkg::SIZE_W-1:0]   size_now_o,
  output logic                         is_empty_o
);

  logic                           acc;
  ils_pkg::cell_cmd_t             cmd;
  logic                           err;
  logic [ils_pkg::IDX_W-1:0]      rd_idx;
  logic [ils_pkg::CNT_W-1:0]      count;
  logic [ils_pkg::CNT_W-1:0]      count_next;
  logic [ils_pkg::VALUE_BITS-1:0] ins_value;
  logic [ils_pkg::VALUE_BITS-1:0] cell_val [ils_pkg::CAPACITY];
  logic [ils_pkg::VALUE_BITS-1:0] rd_data;
  logic                           is_get;

  logic                           done_q;
  logic                           status_q;
  logic [ils_pkg::ITEM_W-1:0]     read_value_q;
  logic [ils_pkg::ITEM_W-1:0]     read_value_d;
  logic [ils_pkg::SIZE_W-1:0]     size_q;
  logic                           empty_q;

  assign busy_o    = 1'b0;
  assign acc       = start_i && !busy_o;
  assign ins_value = ils_pkg::VALUE_BITS'(item_value_i);

  ils_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .operation_i  (operation_i),
    .position_i   (position_i),
    .cmd_o        (cmd),
    .err_o        (err),
    .rd_idx_o     (rd_idx),
    .count_o      (count),
    .count_next_o (count_next)
  );

  for (genvar k = 0; k < ils_pkg::CAPACITY; k++) begin : g_cell
    logic [ils_pkg::VALUE_BITS-1:0] left;
    logic [ils_pkg::VALUE_BITS-1:0] right;

    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_val[k-1];
    end

    if (k == ils_pkg::CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_val[k+1];
    end

    ils_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .own_idx_i   (ils_pkg::IDX_W'(k)),
      .left_i      (left),
      .right_i     (right),
      .ins_value_i (ins_value),
      .value_o     (cell_val[k])
    );
  end

  assign rd_data = cell_val[rd_idx];

  assign is_get = (operation_i == ils_pkg::OP_GET_AT) ||
                  (operation_i == ils_pkg::OP_GET_FRONT) ||
                  (operation_i == ils_pkg::OP_GET_BACK);

  assign read_value_d = (is_get && !err) ? ils_pkg::ITEM_W'(rd_data) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q     <= err;
      read_value_q <= read_value_d;
      size_q       <= ils_pkg::SIZE_W'(count_next);
      empty_q      <= (count_next == '0);
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = read_value_q;
  assign size_now_o   = size_q;
  assign is_empty_o   = empty_q;

`include "indexed_list_store_core_assert.svh"

  `ILS_ASSERT(a_count_bounded, count <= ils_pkg::CNT_W'(ils_pkg::CAPACITY))
  `ILS_ASSERT(a_accept_gives_done, acc |=> done_o)
  `ILS_ASSERT(a_empty_matches_size, done_o |-> (is_empty_o == (size_now_o == '0)))
  `ILS_ASSERT(a_error_reads_zero, (done_o && status_o) |-> (read_value_o == '0))
  `ILS_ASSERT_RST(a_no_done_in_reset, !rst_ni |-> !done_o)

endmodule
